@@ hdl/imtt_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// imtt_pkg - shared types and constants for the task table
// Field widths of the channel words, parameter defaults, command codes,
// controller states and the command bundle sent from controller to cells.
// ============================================================================
package imtt_pkg;

   // Channel field widths
   localparam int OPCODE_BITS        = 2;
   localparam int USER_ID_BITS       = 16;
   localparam int TASK_ID_BITS       = 8;
   localparam int TASK_PRIORITY_BITS = 32;
   localparam int OWNER_USER_BITS    = 16;

   // Parameter defaults
   localparam int TASK_SLOTS_DEFAULT    = 256;
   localparam int USER_BITS_DEFAULT     = 16;
   localparam int PRIORITY_BITS_DEFAULT = 32;

   // Upper limit on log2 of the number of cells in the chain
   localparam int MAX_CELL_BITS = 4;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_ADD    = 2'd0,
      OP_EDIT   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_EXEC   = 2'd3
   } imtt_opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REDUCE
   } imtt_state_type;

   // Command flags broadcast to every cell
   typedef struct packed {
      logic start;   // clear local best before a sweep
      logic scan;    // read the addressed row for the sweep
      logic add;     // write user and priority, set valid
      logic edit;    // write priority if the entry is valid
      logic remove;  // clear valid
      logic clear;   // clear valid of the executed winner
   } imtt_cmd_type;

endpackage

@@ hdl/imtt_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// imtt_if - request and response channels of the task table
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ============================================================================
interface imtt_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [imtt_pkg::OPCODE_BITS-1:0]        opcode;
   logic [imtt_pkg::USER_ID_BITS-1:0]       user_id;
   logic [imtt_pkg::TASK_ID_BITS-1:0]       task_id;
   logic [imtt_pkg::TASK_PRIORITY_BITS-1:0] task_priority;

   modport source (output valid, opcode, user_id, task_id, task_priority, input ready);
   modport sink   (input valid, opcode, user_id, task_id, task_priority, output ready);
endinterface

interface imtt_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 found;
   logic [imtt_pkg::OWNER_USER_BITS-1:0] owner_user;

   modport source (output valid, found, owner_user, input ready);
   modport sink   (input valid, found, owner_user, output ready);
endinterface

@@ hdl/imtt_cell.sv @@
`timescale 1ns / 1ps
// ============================================================================
// imtt_cell - one cell of the selection chain
// Holds the entries whose slot number ends in this cell's index, keeps the
// best entry of its own bank during a sweep, and merges it into the best
// word coming from the previous cell every cycle.
// ============================================================================
module imtt_cell #(
   parameter int CELL_INDEX    = 0,
   parameter int CELL_BITS     = 1,
   parameter int ROWS          = 1,
   parameter int ROW_BITS      = 1,
   parameter int USER_BITS     = imtt_pkg::USER_BITS_DEFAULT,
   parameter int PRIORITY_BITS = imtt_pkg::PRIORITY_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  imtt_pkg::imtt_cmd_type        cmd,
   input  logic [ROW_BITS-1:0]           cmd_row,
   input  logic [CELL_BITS-1:0]          cmd_cell,
   input  logic [USER_BITS-1:0]          cmd_user,
   input  logic [PRIORITY_BITS-1:0]      cmd_prio,
   input  logic                          chain_in_any,
   input  logic [PRIORITY_BITS-1:0]      chain_in_prio,
   input  logic [USER_BITS-1:0]          chain_in_user,
   input  logic [ROW_BITS+CELL_BITS-1:0] chain_in_slot,
   output logic                          chain_out_any,
   output logic [PRIORITY_BITS-1:0]      chain_out_prio,
   output logic [USER_BITS-1:0]          chain_out_user,
   output logic [ROW_BITS+CELL_BITS-1:0] chain_out_slot
);

   localparam int SLOT_BITS = ROW_BITS + CELL_BITS;

   logic [ROWS-1:0]          valid_ff;
   logic [USER_BITS-1:0]     user_mem [ROWS];
   logic [PRIORITY_BITS-1:0] prio_mem [ROWS];

   logic                     rd_live_ff;
   logic [USER_BITS-1:0]     rd_user_ff;
   logic [PRIORITY_BITS-1:0] rd_prio_ff;
   logic [ROW_BITS-1:0]      rd_row_ff;

   logic                     best_any_ff, best_any_in;
   logic [USER_BITS-1:0]     best_user_ff;
   logic [PRIORITY_BITS-1:0] best_prio_ff;
   logic [ROW_BITS-1:0]      best_row_ff;
   logic                     best_take;

   logic                     chain_any_ff;
   logic [USER_BITS-1:0]     chain_user_ff, chain_user_in;
   logic [PRIORITY_BITS-1:0] chain_prio_ff, chain_prio_in;
   logic [SLOT_BITS-1:0]     chain_slot_ff, chain_slot_in;
   logic [SLOT_BITS-1:0]     best_slot;
   logic                     local_wins;

   logic sel;
   logic prio_we;

   assign sel     = (cmd_cell == CELL_BITS'(CELL_INDEX));
   assign prio_we = sel && (cmd.add || (cmd.edit && valid_ff[cmd_row]));

   // Valid marks: set on add, drop on remove or on execution
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (sel && cmd.add) begin
         valid_ff[cmd_row] <= 1'b1;
      end else if (sel && (cmd.remove || cmd.clear)) begin
         valid_ff[cmd_row] <= 1'b0;
      end
   end

   // Entry bank: write user on add, priority on add or edit
   always_ff @(posedge clock) begin
      if (sel && cmd.add) begin
         user_mem[cmd_row] <= cmd_user;
      end
      if (prio_we) begin
         prio_mem[cmd_row] <= cmd_prio;
      end
   end

   // Registered read of the swept row
   always_ff @(posedge clock) begin
      rd_user_ff <= user_mem[cmd_row];
      rd_prio_ff <= prio_mem[cmd_row];
      rd_row_ff  <= cmd_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_live_ff <= 1'b0;
      end else begin
         rd_live_ff <= cmd.scan && valid_ff[cmd_row];
      end
   end

   // Local best: later rows win ties, so the larger slot is kept
   assign best_take = rd_live_ff && (!best_any_ff || (rd_prio_ff >= best_prio_ff));

   always_comb begin
      best_any_in = best_any_ff;
      if (cmd.start) begin
         best_any_in = 1'b0;
      end else if (best_take) begin
         best_any_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_any_ff <= 1'b0;
      end else begin
         best_any_ff <= best_any_in;
      end
   end

   always_ff @(posedge clock) begin
      if (best_take) begin
         best_user_ff <= rd_user_ff;
         best_prio_ff <= rd_prio_ff;
         best_row_ff  <= rd_row_ff;
      end
   end

   // Merge with the upstream word: higher priority, then larger slot
   assign best_slot  = {best_row_ff, CELL_BITS'(CELL_INDEX)};
   assign local_wins = best_any_ff &&
                       (!chain_in_any || (best_prio_ff > chain_in_prio) ||
                        ((best_prio_ff == chain_in_prio) && (best_slot > chain_in_slot)));

   always_comb begin
      if (local_wins) begin
         chain_user_in = best_user_ff;
         chain_prio_in = best_prio_ff;
         chain_slot_in = best_slot;
      end else begin
         chain_user_in = chain_in_user;
         chain_prio_in = chain_in_prio;
         chain_slot_in = chain_in_slot;
      end
   end

   // Advance the chain every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_any_ff <= 1'b0;
      end else begin
         chain_any_ff <= best_any_ff || chain_in_any;
      end
   end

   always_ff @(posedge clock) begin
      chain_user_ff <= chain_user_in;
      chain_prio_ff <= chain_prio_in;
      chain_slot_ff <= chain_slot_in;
   end

   assign chain_out_any  = chain_any_ff;
   assign chain_out_user = chain_user_ff;
   assign chain_out_prio = chain_prio_ff;
   assign chain_out_slot = chain_slot_ff;

endmodule

@@ hdl/imtt_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// imtt_ctrl - request decode, sweep sequencer and response register
// Turns request words into cell commands, runs the row sweep and chain
// settle for an execute, then loads the response and clears the winner.
// ============================================================================
module imtt_ctrl #(
   parameter int TASK_SLOTS    = imtt_pkg::TASK_SLOTS_DEFAULT,
   parameter int CELL_BITS     = 1,
   parameter int ROWS          = 1,
   parameter int ROW_BITS      = 1,
   parameter int USER_BITS     = imtt_pkg::USER_BITS_DEFAULT,
   parameter int PRIORITY_BITS = imtt_pkg::PRIORITY_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   imtt_req_if.sink                      req_bus,
   imtt_rsp_if.source                    rsp_bus,
   output imtt_pkg::imtt_cmd_type        cmd,
   output logic [ROW_BITS-1:0]           cmd_row,
   output logic [CELL_BITS-1:0]          cmd_cell,
   output logic [USER_BITS-1:0]          cmd_user,
   output logic [PRIORITY_BITS-1:0]      cmd_prio,
   input  logic                          end_any,
   input  logic [USER_BITS-1:0]          end_user,
   input  logic [ROW_BITS+CELL_BITS-1:0] end_slot
);

   localparam int SLOT_BITS = ROW_BITS + CELL_BITS;
   localparam int CELLS     = 1 << CELL_BITS;
   localparam int WAIT_LAST = CELLS + 1;
   localparam int WAIT_BITS = $clog2(CELLS + 2);
   localparam int OUB       = imtt_pkg::OWNER_USER_BITS;

   imtt_pkg::imtt_state_type state_ff, state_in;
   logic [ROW_BITS-1:0]      row_ff, row_in;
   logic [WAIT_BITS-1:0]     wait_ff, wait_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [OUB-1:0]           rsp_user_ff, rsp_user_in;
   logic                     load;

   logic                     accept;
   logic                     id_ok;
   logic [SLOT_BITS-1:0]     req_slot;

   // Take a new word only while idle
   assign req_bus.ready = (state_ff == imtt_pkg::ST_IDLE);

   assign accept   = req_bus.valid && req_bus.ready;
   assign id_ok    = (32'(req_bus.task_id) < 32'(TASK_SLOTS));
   assign req_slot = SLOT_BITS'(req_bus.task_id);
   assign cmd_user = USER_BITS'(req_bus.user_id);
   assign cmd_prio = PRIORITY_BITS'(req_bus.task_priority);

   // State and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= imtt_pkg::ST_IDLE;
         row_ff       <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response word
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_found_ff <= rsp_found_in;
         rsp_user_ff  <= rsp_user_in;
      end
   end

   // Next state, cell commands and response load
   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      wait_in       = wait_ff;
      cmd           = '0;
      cmd_row       = req_slot[SLOT_BITS-1:CELL_BITS];
      cmd_cell      = req_slot[CELL_BITS-1:0];
      load          = 1'b0;
      rsp_found_in  = end_any;
      rsp_user_in   = end_any ? OUB'(end_user) : '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;

      case (state_ff)
         imtt_pkg::ST_IDLE: begin
            if (accept) begin
               case (imtt_pkg::imtt_opcode_type'(req_bus.opcode))
                  imtt_pkg::OP_ADD:    cmd.add    = id_ok;
                  imtt_pkg::OP_EDIT:   cmd.edit   = id_ok;
                  imtt_pkg::OP_REMOVE: cmd.remove = id_ok;
                  imtt_pkg::OP_EXEC: begin
                     cmd.start = 1'b1;
                     row_in    = '0;
                     state_in  = imtt_pkg::ST_SCAN;
                  end
                  default: cmd = '0;
               endcase
            end
         end
         imtt_pkg::ST_SCAN: begin
            // sweep one row of every bank per cycle
            cmd.scan = 1'b1;
            cmd_row  = row_ff;
            if (row_ff == ROW_BITS'(ROWS - 1)) begin
               wait_in  = '0;
               state_in = imtt_pkg::ST_REDUCE;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         imtt_pkg::ST_REDUCE: begin
            // let the winner walk to the end of the chain, then hand it out
            cmd_row  = end_slot[SLOT_BITS-1:CELL_BITS];
            cmd_cell = end_slot[CELL_BITS-1:0];
            if (wait_ff != WAIT_BITS'(WAIT_LAST)) begin
               wait_in = wait_ff + 1'b1;
            end else if (!rsp_valid_ff || rsp_bus.ready) begin
               load         = 1'b1;
               rsp_valid_in = 1'b1;
               cmd.clear    = end_any;
               state_in     = imtt_pkg::ST_IDLE;
            end
         end
         default: state_in = imtt_pkg::ST_IDLE;
      endcase
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.found      = rsp_found_ff;
   assign rsp_bus.owner_user = rsp_user_ff;

endmodule

@@ hdl/indexed_max_priority_task_table_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// indexed_max_priority_task_table_top - task table with max-priority execute
// Slot-indexed task store; execute returns and retires the highest-priority
// task, ties going to the larger task id.
// ============================================================================
// Add, edit and remove are done in the idle state and a new word can be taken
// the next cycle. An execute keeps the request side busy through a sweep that
// reads one row of every cell's single-port bank per cycle over all ROWS rows,
// plus the walk of the best candidate down the chain of CELLS cells, where
// CELLS = 2**min(4, clog2(TASK_SLOTS)) and ROWS = TASK_SLOTS / CELLS rounded
// up. The response sits in an output register, so a waiting response does not
// block adds, edits or removes; a later execute only waits at its end for that
// register to free up. Task ids at or above TASK_SLOTS are ignored by add,
// edit and remove.
module indexed_max_priority_task_table_top #(
   parameter int TASK_SLOTS    = imtt_pkg::TASK_SLOTS_DEFAULT,
   parameter int USER_BITS     = imtt_pkg::USER_BITS_DEFAULT,
   parameter int PRIORITY_BITS = imtt_pkg::PRIORITY_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   imtt_req_if.sink   req_bus,
   imtt_rsp_if.source rsp_bus
);

   localparam int CELL_BITS = ($clog2(TASK_SLOTS) < imtt_pkg::MAX_CELL_BITS) ?
                              $clog2(TASK_SLOTS) : imtt_pkg::MAX_CELL_BITS;
   localparam int CELLS     = 1 << CELL_BITS;
   localparam int ROWS      = (TASK_SLOTS + CELLS - 1) / CELLS;
   localparam int ROW_BITS  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SLOT_BITS = ROW_BITS + CELL_BITS;

   imtt_pkg::imtt_cmd_type   cmd;
   logic [ROW_BITS-1:0]      cmd_row;
   logic [CELL_BITS-1:0]     cmd_cell;
   logic [USER_BITS-1:0]     cmd_user;
   logic [PRIORITY_BITS-1:0] cmd_prio;

   logic                     chain_any  [CELLS+1];
   logic [PRIORITY_BITS-1:0] chain_prio [CELLS+1];
   logic [USER_BITS-1:0]     chain_user [CELLS+1];
   logic [SLOT_BITS-1:0]     chain_slot [CELLS+1];

   // Controller
   imtt_ctrl #(
      .TASK_SLOTS    (TASK_SLOTS),
      .CELL_BITS     (CELL_BITS),
      .ROWS          (ROWS),
      .ROW_BITS      (ROW_BITS),
      .USER_BITS     (USER_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .cmd      (cmd),
      .cmd_row  (cmd_row),
      .cmd_cell (cmd_cell),
      .cmd_user (cmd_user),
      .cmd_prio (cmd_prio),
      .end_any  (chain_any[CELLS]),
      .end_user (chain_user[CELLS]),
      .end_slot (chain_slot[CELLS])
   );

   // Head of the chain carries no candidate
   assign chain_any[0]  = 1'b0;
   assign chain_prio[0] = '0;
   assign chain_user[0] = '0;
   assign chain_slot[0] = '0;

   // Chain of cells
   for (genvar g = 0; g < CELLS; g++) begin : g_cell
      imtt_cell #(
         .CELL_INDEX    (g),
         .CELL_BITS     (CELL_BITS),
         .ROWS          (ROWS),
         .ROW_BITS      (ROW_BITS),
         .USER_BITS     (USER_BITS),
         .PRIORITY_BITS (PRIORITY_BITS)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .cmd            (cmd),
         .cmd_row        (cmd_row),
         .cmd_cell       (cmd_cell),
         .cmd_user       (cmd_user),
         .cmd_prio       (cmd_prio),
         .chain_in_any   (chain_any[g]),
         .chain_in_prio  (chain_prio[g]),
         .chain_in_user  (chain_user[g]),
         .chain_in_slot  (chain_slot[g]),
         .chain_out_any  (chain_any[g+1]),
         .chain_out_prio (chain_prio[g+1]),
         .chain_out_user (chain_user[g+1]),
         .chain_out_slot (chain_slot[g+1])
      );
   end

`ifndef NO_ASSERTIONS
   // An accepted execute holds off the request side in the next cycle
   a_exec_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && (req_bus.opcode == imtt_pkg::OP_EXEC))
      |=> !req_bus.ready)
      else $error("request side ready right after an execute was taken");

   // A new response is only loaded at the end of an execute
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(!req_bus.ready))
      else $error("response appeared without an execute in progress");

   // An empty-table response reports user zero
   a_empty_user_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.found) |-> (rsp_bus.owner_user == '0))
      else $error("not-found response with nonzero owner user");
`endif

endmodule
